[rtl/core/tricycle_wheel_kinematics_top_assert.svh]
// Assertion macros for the tricycle wheel kinematics block.
`ifndef TRICYCLE_WHEEL_KINEMATICS_TOP_ASSERT_SVH
`define TRICYCLE_WHEEL_KINEMATICS_TOP_ASSERT_SVH
`ifndef ASSERT_OFF
`define TWK_ASSERT_IMPL(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("assertion failed");
`define TWK_ASSERT_NEVER(label, clk, rst_n, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("forbidden condition");
`else
`define TWK_ASSERT_IMPL(label, clk, rst_n, prop)
`define TWK_ASSERT_NEVER(label, clk, rst_n, cond)
`endif
`endif

[rtl/core/twk_pkg.sv]
package twk_pkg;

    localparam int CORDIC_STEPS = 16;
    localparam int ANGLE_MAX    = 102944;
    localparam logic signed [33:0] GAIN_INV_Q30 = 34'sd652032874;

    localparam logic [1:0] REG_STEER_LIMIT = 2'd0;
    localparam logic [1:0] REG_WHEELBASE   = 2'd1;
    localparam logic [1:0] REG_TRACK       = 2'd2;
    localparam logic [1:0] REG_SPEED_CAP   = 2'd3;

    // Angle classes decided by the front end.
    typedef enum logic [1:0] {
        ANG_CORDIC = 2'd0,
        ANG_ZERO   = 2'd1,
        ANG_POS    = 2'd2,
        ANG_NEG    = 2'd3
    } ang_kind_t;

    // One classified command handed from the front end to the back end.
    typedef struct packed {
        logic signed [31:0] fwd_speed;
        logic signed [31:0] turn_rate;
        ang_kind_t          kind;
        logic [16:0]        limit;
        logic [19:0]        wheelbase;
        logic [19:0]        track;
        logic [30:0]        cap;
    } cmd_t;

    // Side-band width carried along the quotient pipelines: a spare bit,
    // the command, the angle and the centre speed.
    localparam int DIV_TAG_W = 1 + $bits(cmd_t) + 18 + 64;

    // Arctangent of 2^-i in Q30, truncated.
    function automatic logic signed [31:0] atan_q30(input logic [4:0] idx);
        logic signed [31:0] r;
        case (idx)
            5'd0: r = 32'sd843314856;  5'd1: r = 32'sd497837829;
            5'd2: r = 32'sd263043836;  5'd3: r = 32'sd133525158;
            5'd4: r = 32'sd67021686;   5'd5: r = 32'sd33543515;
            5'd6: r = 32'sd16775850;   5'd7: r = 32'sd8388437;
            5'd8: r = 32'sd4194282;    5'd9: r = 32'sd2097149;
            5'd10: r = 32'sd1048575;   5'd11: r = 32'sd524287;
            5'd12: r = 32'sd262143;    5'd13: r = 32'sd131071;
            5'd14: r = 32'sd65535;     5'd15: r = 32'sd32767;
            5'd16: r = 32'sd16383;     5'd17: r = 32'sd8191;
            5'd18: r = 32'sd4095;      5'd19: r = 32'sd2047;
            5'd20: r = 32'sd1023;      5'd21: r = 32'sd511;
            5'd22: r = 32'sd255;       5'd23: r = 32'sd127;
            5'd24: r = 32'sd63;        5'd25: r = 32'sd31;
            5'd26: r = 32'sd15;        5'd27: r = 32'sd7;
            5'd28: r = 32'sd3;         5'd29: r = 32'sd1;
            default: r = 32'sd0;
        endcase
        return r;
    endfunction

endpackage

[rtl/core/twk_front.sv]
// Front end: registers configuration, classifies commands, and holds a
// two-entry queue toward the back end.
module twk_front (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [63:0]          s_tdata,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [1:0]           cfg_index,
    input  logic [30:0]          cfg_data,
    output logic                 q_valid,
    input  logic                 q_ready,
    output twk_pkg::cmd_t        q_cmd
);

    logic [16:0] limit_reg;
    logic [19:0] wheelbase_reg;
    logic [19:0] track_reg;
    logic [30:0] cap_reg;
    twk_pkg::cmd_t q_mem_reg [2];
    logic          wr_ptr_reg, rd_ptr_reg;
    logic [1:0]    count_reg, count_next;
    twk_pkg::cmd_t cmd;
    logic          push, pop;

    assign cfg_ready = 1'b1;

    // Configuration registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            limit_reg     <= 17'd32768;
            wheelbase_reg <= 20'd65536;
            track_reg     <= 20'd65536;
            cap_reg       <= 31'd2621440;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                twk_pkg::REG_STEER_LIMIT: limit_reg     <= cfg_data[16:0];
                twk_pkg::REG_WHEELBASE:   wheelbase_reg <= cfg_data[19:0];
                twk_pkg::REG_TRACK:       track_reg     <= cfg_data[19:0];
                twk_pkg::REG_SPEED_CAP:   cap_reg       <= cfg_data;
                default: ;
            endcase
        end
    end

    // Classify the command and resolve register special cases.
    always_comb begin
        cmd.fwd_speed = s_tdata[31:0];
        cmd.turn_rate = s_tdata[63:32];
        if (cmd.fwd_speed == 32'sd0) begin
            cmd.kind = (cmd.turn_rate > 32'sd0) ? twk_pkg::ANG_POS : twk_pkg::ANG_NEG;
        end else if (cmd.turn_rate == 32'sd0) begin
            cmd.kind = twk_pkg::ANG_ZERO;
        end else begin
            cmd.kind = twk_pkg::ANG_CORDIC;
        end
        cmd.limit     = (limit_reg > 17'(twk_pkg::ANGLE_MAX)) ?
                        17'(twk_pkg::ANGLE_MAX) : limit_reg;
        cmd.wheelbase = (wheelbase_reg == 20'd0) ? 20'd1 : wheelbase_reg;
        cmd.track     = track_reg;
        cmd.cap       = cap_reg;
    end

    // Two-entry queue.
    assign s_tready = (count_reg != 2'd2);
    assign push     = s_tvalid && s_tready;
    assign q_valid  = (count_reg != 2'd0);
    assign pop      = q_valid && q_ready;
    assign q_cmd    = q_mem_reg[rd_ptr_reg];

    always_comb begin
        count_next = count_reg;
        if (push && !pop) count_next = count_reg + 2'd1;
        if (pop && !push) count_next = count_reg - 2'd1;
    end

    always_ff @(posedge aclk) begin
        if (push) q_mem_reg[wr_ptr_reg] <= cmd;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            if (push) wr_ptr_reg <= ~wr_ptr_reg;
            if (pop)  rd_ptr_reg <= ~rd_ptr_reg;
            count_reg <= count_next;
        end
    end

endmodule

[rtl/core/twk_div.sv]
// Pipelined restoring divider for a rounded product quotient: one quotient
// bit per stage over a 128 bit dividend, with a side-band tag carried along.
module twk_div (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          en,
    input  logic                          in_valid,
    input  logic [127:0]                  in_num,
    input  logic [63:0]                   in_den,
    input  logic                          in_neg,
    input  logic [twk_pkg::DIV_TAG_W-1:0] in_tag,
    output logic                          out_valid,
    output logic signed [63:0]            out_quo,
    output logic [twk_pkg::DIV_TAG_W-1:0] out_tag
);

    localparam int N  = 128;
    localparam int TW = twk_pkg::DIV_TAG_W;

    logic [N:0]       vld_reg;
    logic [127:0]     num_reg [N+1];
    logic [64:0]      rem_reg [N+1];
    logic [63:0]      quo_reg [N+1];
    logic [63:0]      den_reg [N+1];
    logic             neg_reg [N+1];
    logic [TW-1:0]    tag_reg [N+1];

    always_comb begin
        num_reg[0] = in_num + {64'd0, 1'b0, in_den[63:1]};
        rem_reg[0] = 65'd0;
        quo_reg[0] = 64'd0;
        den_reg[0] = in_den;
        neg_reg[0] = in_neg;
        tag_reg[0] = in_tag;
        vld_reg[0] = in_valid;
    end

    // One quotient bit per stage.
    for (genvar k = 0; k < N; k++) begin : g_st
        logic [64:0] r;
        logic        ge;
        assign r  = {rem_reg[k][63:0], num_reg[k][127]};
        assign ge = (r >= {1'b0, den_reg[k]});
        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                vld_reg[k+1] <= 1'b0;
            end else if (en) begin
                vld_reg[k+1] <= vld_reg[k];
            end
        end
        always_ff @(posedge aclk) begin
            if (en) begin
                num_reg[k+1] <= {num_reg[k][126:0], 1'b0};
                rem_reg[k+1] <= ge ? (r - {1'b0, den_reg[k]}) : r;
                quo_reg[k+1] <= {quo_reg[k][62:0], ge};
                den_reg[k+1] <= den_reg[k];
                neg_reg[k+1] <= neg_reg[k];
                tag_reg[k+1] <= tag_reg[k];
            end
        end
    end

    assign out_valid = vld_reg[N];
    assign out_quo   = (den_reg[N] == 64'd0) ? 64'sd0 :
                       (neg_reg[N] ? -$signed(quo_reg[N]) : $signed(quo_reg[N]));
    assign out_tag   = tag_reg[N];

endmodule

[rtl/core/twk_back.sv]
// Back end: a pipeline of vectoring CORDIC, clamp, rotation CORDIC,
// wheel speed quotients, peak search, cap scaling and saturation. The
// whole pipeline advances together when the output stage can accept.
module twk_back (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          q_valid,
    output logic          q_ready,
    input  twk_pkg::cmd_t q_cmd,
    output logic          m_tvalid,
    input  logic          m_tready,
    output logic [95:0]   m_tdata_lo,
    output logic [17:0]   m_angle
);

    localparam int S = twk_pkg::CORDIC_STEPS;

    logic en;
    logic out_vld_reg;
    assign en      = !out_vld_reg || m_tready;
    assign q_ready = en;

    // ---------------- Vectoring CORDIC ----------------
    logic          vv_reg [S+1];
    twk_pkg::cmd_t vc_reg [S+1];
    logic signed [63:0] vx_reg [S+1];
    logic signed [63:0] vy_reg [S+1];
    logic signed [35:0] vz_reg [S+1];

    logic [31:0] vmag;
    logic signed [52:0] lw;
    always_comb begin
        vmag = q_cmd.fwd_speed[31] ? 32'(-q_cmd.fwd_speed) : 32'(q_cmd.fwd_speed);
        lw   = $signed({1'b0, q_cmd.wheelbase}) * q_cmd.turn_rate;
        vv_reg[0] = q_valid;
        vc_reg[0] = q_cmd;
        vx_reg[0] = $signed({16'd0, vmag, 16'd0});
        vy_reg[0] = q_cmd.fwd_speed[31] ? -64'(lw) : 64'(lw);
        vz_reg[0] = 36'sd0;
    end

    for (genvar i = 0; i < S; i++) begin : g_vec
        logic signed [63:0] xs, ys;
        assign xs = vx_reg[i] >>> i;
        assign ys = vy_reg[i] >>> i;
        always_ff @(posedge aclk) begin
            if (!aresetn) vv_reg[i+1] <= 1'b0;
            else if (en)  vv_reg[i+1] <= vv_reg[i];
        end
        always_ff @(posedge aclk) begin
            if (en) begin
                vc_reg[i+1] <= vc_reg[i];
                if (vy_reg[i] >= 0) begin
                    vx_reg[i+1] <= vx_reg[i] + ys;
                    vy_reg[i+1] <= vy_reg[i] - xs;
                    vz_reg[i+1] <= vz_reg[i] + 36'(twk_pkg::atan_q30(5'(i)));
                end else begin
                    vx_reg[i+1] <= vx_reg[i] - ys;
                    vy_reg[i+1] <= vy_reg[i] + xs;
                    vz_reg[i+1] <= vz_reg[i] - 36'(twk_pkg::atan_q30(5'(i)));
                end
            end
        end
    end

    // ---------------- Angle select and clamp ----------------
    logic          av_reg;
    twk_pkg::cmd_t ac_reg;
    logic signed [17:0] ang_reg;
    logic signed [35:0] zr;
    logic signed [21:0] raw;
    logic signed [21:0] lim;
    logic signed [17:0] ang_next;
    always_comb begin
        zr  = (vz_reg[S] + 36'sd8192) >>> 14;
        lim = $signed({5'd0, vc_reg[S].limit});
        unique case (vc_reg[S].kind)
            twk_pkg::ANG_POS:  raw = lim;
            twk_pkg::ANG_NEG:  raw = -lim;
            twk_pkg::ANG_ZERO: raw = 22'sd0;
            default:           raw = zr[21:0];
        endcase
        if (raw > lim)       ang_next = 18'(lim);
        else if (raw < -lim) ang_next = 18'(-lim);
        else                 ang_next = raw[17:0];
    end
    always_ff @(posedge aclk) begin
        if (!aresetn) av_reg <= 1'b0;
        else if (en)  av_reg <= vv_reg[S];
    end
    always_ff @(posedge aclk) begin
        if (en) begin
            ac_reg  <= vc_reg[S];
            ang_reg <= ang_next;
        end
    end

    // ---------------- Rotation CORDIC ----------------
    logic          rv_reg [S+1];
    twk_pkg::cmd_t rc_reg [S+1];
    logic signed [17:0] ra_reg [S+1];
    logic signed [33:0] rx_reg [S+1];
    logic signed [33:0] ry_reg [S+1];
    logic signed [35:0] rz_reg [S+1];
    always_comb begin
        rv_reg[0] = av_reg;
        rc_reg[0] = ac_reg;
        ra_reg[0] = ang_reg;
        rx_reg[0] = twk_pkg::GAIN_INV_Q30;
        ry_reg[0] = 34'sd0;
        rz_reg[0] = 36'(ang_reg) <<< 14;
    end
    for (genvar i = 0; i < S; i++) begin : g_rot
        logic signed [33:0] xs, ys;
        assign xs = rx_reg[i] >>> i;
        assign ys = ry_reg[i] >>> i;
        always_ff @(posedge aclk) begin
            if (!aresetn) rv_reg[i+1] <= 1'b0;
            else if (en)  rv_reg[i+1] <= rv_reg[i];
        end
        always_ff @(posedge aclk) begin
            if (en) begin
                rc_reg[i+1] <= rc_reg[i];
                ra_reg[i+1] <= ra_reg[i];
                if (rz_reg[i] >= 0) begin
                    rx_reg[i+1] <= rx_reg[i] - ys;
                    ry_reg[i+1] <= ry_reg[i] + xs;
                    rz_reg[i+1] <= rz_reg[i] - 36'(twk_pkg::atan_q30(5'(i)));
                end else begin
                    rx_reg[i+1] <= rx_reg[i] + ys;
                    ry_reg[i+1] <= ry_reg[i] - xs;
                    rz_reg[i+1] <= rz_reg[i] + 36'(twk_pkg::atan_q30(5'(i)));
                end
            end
        end
    end

    // ---------------- Products: v*cos, v*sin, then v*sin*T ----------------
    logic          pv_reg;
    twk_pkg::cmd_t pc_reg;
    logic signed [17:0] pa_reg;
    logic signed [65:0] vc_prod_reg, vs_prod_reg;
    logic signed [65:0] vc_prod_next, vs_prod_next;
    assign vc_prod_next = 66'(rc_reg[S].fwd_speed) * 66'(rx_reg[S]);
    assign vs_prod_next = 66'(rc_reg[S].fwd_speed) * 66'(ry_reg[S]);
    always_ff @(posedge aclk) begin
        if (!aresetn) pv_reg <= 1'b0;
        else if (en)  pv_reg <= rv_reg[S];
    end
    always_ff @(posedge aclk) begin
        if (en) begin
            pc_reg      <= rc_reg[S];
            pa_reg      <= ra_reg[S];
            vc_prod_reg <= vc_prod_next;
            vs_prod_reg <= vs_prod_next;
        end
    end

    // The |v*s|*T product is kept as two 32 by 20 bit partial products.
    logic          tv_reg;
    twk_pkg::cmd_t tc_reg;
    logic signed [17:0] ta_reg;
    logic signed [65:0] tvc_reg;
    logic [51:0]   tnlo_reg, tnhi_reg;
    logic [127:0]  tnum;
    logic          tneg_reg;
    logic [63:0]   vs_mag;
    assign vs_mag = vs_prod_reg[65] ? 64'(-vs_prod_reg) : 64'(vs_prod_reg);
    always_ff @(posedge aclk) begin
        if (!aresetn) tv_reg <= 1'b0;
        else if (en)  tv_reg <= pv_reg;
    end
    always_ff @(posedge aclk) begin
        if (en) begin
            tc_reg   <= pc_reg;
            ta_reg   <= pa_reg;
            tvc_reg  <= vc_prod_reg;
            tnlo_reg <= 52'(vs_mag[31:0]) * 52'(pc_reg.track);
            tnhi_reg <= 52'(vs_mag[63:32]) * 52'(pc_reg.track);
            tneg_reg <= vs_prod_reg[65] && (pc_reg.track != 20'd0);
        end
    end
    assign tnum = {44'd0, tnhi_reg, 32'd0} + {76'd0, tnlo_reg};

    // ---------------- diff = v*s*T / (L*2^31) ----------------
    localparam int TAG1 = twk_pkg::DIV_TAG_W;
    logic [TAG1-1:0] d1_tag;
    logic            d1_v;
    logic signed [63:0] d1_q;
    logic signed [63:0] centre;
    logic [63:0]     vc_mag;
    logic signed [63:0] vc_rnd;
    assign vc_mag = tvc_reg[65] ? 64'(-tvc_reg) : 64'(tvc_reg);
    assign vc_rnd = $signed((vc_mag + 64'd536870912) >> 30);
    assign centre = tvc_reg[65] ? -vc_rnd : vc_rnd;

    twk_div u_diff (
        .aclk(aclk), .aresetn(aresetn), .en(en),
        .in_valid(tv_reg), .in_num(tnum),
        .in_den({13'd0, tc_reg.wheelbase, 31'd0}), .in_neg(tneg_reg),
        .in_tag({1'b0, tc_reg, ta_reg, centre}),
        .out_valid(d1_v), .out_quo(d1_q), .out_tag(d1_tag)
    );

    twk_pkg::cmd_t   d1_cmd;
    logic signed [17:0] d1_ang;
    logic signed [63:0] d1_ctr;
    assign {d1_cmd, d1_ang, d1_ctr} = d1_tag[TAG1-2:0];

    // ---------------- Speeds and peak ----------------
    logic          sv_reg;
    twk_pkg::cmd_t sc_reg;
    logic signed [17:0] sa_reg;
    logic signed [63:0] sp_reg [3];
    logic signed [63:0] sp_next [3];
    always_comb begin
        sp_next[0] = d1_ctr + d1_q;
        sp_next[1] = d1_ctr - d1_q;
        sp_next[2] = 64'(d1_cmd.fwd_speed);
    end
    always_ff @(posedge aclk) begin
        if (!aresetn) sv_reg <= 1'b0;
        else if (en)  sv_reg <= d1_v;
    end
    always_ff @(posedge aclk) begin
        if (en) begin
            sc_reg <= d1_cmd;
            sa_reg <= d1_ang;
            for (int j = 0; j < 3; j++) sp_reg[j] <= sp_next[j];
        end
    end

    logic [63:0] m0, m1, m2, pk01, peak;
    assign m0   = sp_reg[0][63] ? 64'(-sp_reg[0]) : 64'(sp_reg[0]);
    assign m1   = sp_reg[1][63] ? 64'(-sp_reg[1]) : 64'(sp_reg[1]);
    assign m2   = sp_reg[2][63] ? 64'(-sp_reg[2]) : 64'(sp_reg[2]);
    assign pk01 = (m1 > m0) ? m1 : m0;
    assign peak = (m2 > pk01) ? m2 : pk01;

    // Register the peak and the speed times cap as 32 by 31 bit partials.
    logic          kv_reg;
    logic signed [17:0] ka_reg;
    logic signed [63:0] ksp_reg [3];
    logic [63:0]   kpeak_reg;
    logic [30:0]   kcap_reg;
    logic          kscale_reg;
    logic [62:0]   kplo_reg [3];
    logic [62:0]   kphi_reg [3];
    always_ff @(posedge aclk) begin
        if (!aresetn) kv_reg <= 1'b0;
        else if (en)  kv_reg <= sv_reg;
    end
    always_ff @(posedge aclk) begin
        if (en) begin
            ka_reg      <= sa_reg;
            kpeak_reg   <= peak;
            kcap_reg    <= sc_reg.cap;
            kscale_reg  <= peak > 64'(sc_reg.cap);
            kplo_reg[0] <= 63'(m0[31:0]) * 63'(sc_reg.cap);
            kphi_reg[0] <= 63'(m0[63:32]) * 63'(sc_reg.cap);
            kplo_reg[1] <= 63'(m1[31:0]) * 63'(sc_reg.cap);
            kphi_reg[1] <= 63'(m1[63:32]) * 63'(sc_reg.cap);
            kplo_reg[2] <= 63'(m2[31:0]) * 63'(sc_reg.cap);
            kphi_reg[2] <= 63'(m2[63:32]) * 63'(sc_reg.cap);
            for (int j = 0; j < 3; j++) ksp_reg[j] <= sp_reg[j];
        end
    end

    // ---------------- Cap scaling: three quotient lanes ----------------
    localparam int CAP_TAG_W = 18 + 1 + 192;
    logic               cv [3];
    logic signed [63:0] cq [3];
    logic [TAG1-1:0]    ctag [3];
    for (genvar j = 0; j < 3; j++) begin : g_cap
        logic [127:0] cnum;
        assign cnum = {33'd0, kphi_reg[j], 32'd0} + {65'd0, kplo_reg[j]};
        twk_div u_cap (
            .aclk(aclk), .aresetn(aresetn), .en(en),
            .in_valid(kv_reg), .in_num(cnum),
            .in_den(kpeak_reg),
            .in_neg(ksp_reg[j][63] && (kcap_reg != 31'd0)),
            .in_tag(TAG1'({ka_reg, kscale_reg, ksp_reg[0], ksp_reg[1], ksp_reg[2]})),
            .out_valid(cv[j]), .out_quo(cq[j]), .out_tag(ctag[j])
        );
    end

    // ---------------- Saturation and output register ----------------
    logic signed [17:0] f_ang;
    logic               f_scale;
    logic signed [63:0] f_sp [3];
    logic [31:0]        sat [3];
    assign {f_ang, f_scale, f_sp[0], f_sp[1], f_sp[2]} = ctag[0][CAP_TAG_W-1:0];
    always_comb begin
        for (int j = 0; j < 3; j++) begin
            logic signed [63:0] v;
            v = f_scale ? cq[j] : f_sp[j];
            if (v > 64'sd2147483647)       sat[j] = 32'h7FFFFFFF;
            else if (v < -64'sd2147483648) sat[j] = 32'h80000000;
            else                           sat[j] = v[31:0];
        end
    end

    logic [95:0]  out_data_reg;
    logic [17:0]  out_ang_reg;
    always_ff @(posedge aclk) begin
        if (!aresetn) out_vld_reg <= 1'b0;
        else if (en)  out_vld_reg <= cv[0];
    end
    always_ff @(posedge aclk) begin
        if (en) begin
            out_data_reg <= {sat[2], sat[1], sat[0]};
            out_ang_reg  <= f_ang;
        end
    end
    assign m_tvalid   = out_vld_reg;
    assign m_tdata_lo = out_data_reg;
    assign m_angle    = out_ang_reg;

    `include "tricycle_wheel_kinematics_top_assert.svh"
    `TWK_ASSERT_IMPL(a_hold, aclk, aresetn, m_tvalid && !m_tready |=> m_tvalid)
    `TWK_ASSERT_IMPL(a_lanes, aclk, aresetn, cv[0] == cv[2])
    `TWK_ASSERT_NEVER(a_ang, aclk, aresetn, out_vld_reg &&
        (($signed(out_ang_reg) > 18'sd102944) || ($signed(out_ang_reg) < -18'sd102944)))

endmodule

[rtl/core/tricycle_wheel_kinematics_top.sv]
// Tricycle inverse kinematics.
// Input channel s_*: one item per command, tdata = {turn_rate, fwd_speed}.
// Result channel m_*: one item per command, tdata from bit 0 up:
// left_speed, right_speed, rear_speed, steer_angle, zero filled to 120 bits.
// Configuration channel cfg_*: index 0 steer limit, 1 wheelbase, 2 track,
// 3 speed cap; always ready. Users must write it only while the block is
// idle; the block itself does not enforce this. Throughput: one item per
// cycle while the receiver does not stall. Items pass through two 16-step
// CORDIC pipelines, the multiplier stages, two 128-stage quotient pipelines
// in series and the registers between them.
// Reset (aresetn low, synchronous) empties the pipeline and the front
// queue and restores register defaults.
// When the receiver stalls, the whole back pipeline holds; the two-entry
// front queue keeps taking items until it is full, then s_tready drops.
module tricycle_wheel_kinematics_top (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [63:0]  s_tdata,   // fwd_speed, turn_rate
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [119:0] m_tdata,   // left, right, rear, steer_angle
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic [1:0]   cfg_index,
    input  logic [30:0]  cfg_data
);

    logic          q_valid, q_ready;
    twk_pkg::cmd_t q_cmd;
    logic [95:0]   lo;
    logic [17:0]   ang;

    twk_front u_front (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data),
        .q_valid(q_valid), .q_ready(q_ready), .q_cmd(q_cmd)
    );

    twk_back u_back (
        .aclk(aclk), .aresetn(aresetn),
        .q_valid(q_valid), .q_ready(q_ready), .q_cmd(q_cmd),
        .m_tvalid(m_tvalid), .m_tready(m_tready),
        .m_tdata_lo(lo), .m_angle(ang)
    );

    // Pack the result item.
    assign m_tdata = {6'd0, ang, lo};

endmodule

[sim/tb_kinematics_checker.sv]
`default_nettype none

module tb_kinematics_checker (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    input  logic         s_tready,
    input  logic [63:0]  s_tdata,
    input  logic         m_tvalid,
    input  logic         m_tready,
    input  logic [119:0] m_tdata,
    input  logic         cfg_valid,
    input  logic         cfg_ready,
    input  logic [1:0]   cfg_index,
    input  logic [30:0]  cfg_data,
    output int           fail_count,
    output int           pending_count
);
    timeunit 1ns;
    timeprecision 1ps;

    // One predicted set of wheel commands.
    typedef struct packed {
        logic signed [31:0] left;
        logic signed [31:0] right;
        logic signed [31:0] rear;
        logic signed [17:0] angle;
    } wheel_cmd_t;

    wheel_cmd_t wheel_queue[$];

    logic [16:0] lim_reg;
    logic [19:0] base_reg;
    logic [19:0] track_reg;
    logic [30:0] cap_reg;

    // Arithmetic shift right of a wide signed value.
    function automatic logic signed [127:0] asr128(input logic signed [127:0] x, input int s);
        return x >>> s;
    endfunction

    // Product over divisor, rounded half away from zero; zero divisor gives zero.
    function automatic logic signed [127:0] scaled_div(input logic signed [127:0] a,
                                                       input logic signed [127:0] b,
                                                       input logic [127:0] d);
        logic [255:0] pa, pb, q;
        logic neg;
        if (d == 0) return 0;
        neg = (a < 0) != (b < 0);
        pa = (a < 0) ? -a : a;
        pb = (b < 0) ? -b : b;
        q = (pa * pb + (d >> 1)) / d;
        return neg ? -$signed(q[127:0]) : $signed(q[127:0]);
    endfunction

    function automatic logic signed [127:0] clip32(input logic signed [127:0] x);
        if (x > 128'sd2147483647) return 128'sd2147483647;
        if (x < -128'sd2147483648) return -128'sd2147483648;
        return x;
    endfunction

    // Steering angle and wheel speeds for one command.
    function automatic wheel_cmd_t tricycle_kinematics(input logic signed [31:0] v32,
                                                       input logic signed [31:0] w32);
        logic signed [127:0] v, w, len, lim, ang, x, y, z, xs, ys, c, s;
        logic signed [127:0] centre, diff, peak, cap, mg;
        logic signed [127:0] sp[3];
        wheel_cmd_t r;
        v = v32;
        w = w32;
        len = (base_reg == 0) ? 1 : base_reg;
        lim = (lim_reg > twk_pkg::ANGLE_MAX) ? twk_pkg::ANGLE_MAX : lim_reg;
        if (v == 0) begin
            ang = (w > 0) ? lim : -lim;
        end else if (w == 0) begin
            ang = 0;
        end else begin
            x = ((v < 0) ? -v : v) <<< 16;
            y = (v < 0) ? -(len * w) : len * w;
            z = 0;
            for (int i = 0; i < twk_pkg::CORDIC_STEPS && i < 30; i++) begin
                xs = asr128(x, i);
                ys = asr128(y, i);
                if (y >= 0) begin
                    x += ys; y -= xs; z += twk_pkg::atan_q30(i[4:0]);
                end else begin
                    x -= ys; y += xs; z -= twk_pkg::atan_q30(i[4:0]);
                end
            end
            ang = asr128(z + 8192, 14);
        end
        if (ang > lim) ang = lim;
        if (ang < -lim) ang = -lim;

        // Cosine and sine of the clamped angle.
        x = twk_pkg::GAIN_INV_Q30;
        y = 0;
        z = ang * 16384;
        for (int i = 0; i < twk_pkg::CORDIC_STEPS && i < 30; i++) begin
            xs = asr128(x, i);
            ys = asr128(y, i);
            if (z >= 0) begin
                x -= ys; y += xs; z -= twk_pkg::atan_q30(i[4:0]);
            end else begin
                x += ys; y -= xs; z += twk_pkg::atan_q30(i[4:0]);
            end
        end
        c = x;
        s = y;

        centre = scaled_div(v, c, 128'd1 << 30);
        diff = scaled_div(v * s, track_reg, len << 31);
        sp[0] = centre + diff;
        sp[1] = centre - diff;
        sp[2] = v;

        // Scale down to the speed cap, keeping the ratios.
        peak = 0;
        for (int j = 0; j < 3; j++) begin
            mg = (sp[j] < 0) ? -sp[j] : sp[j];
            if (mg > peak) peak = mg;
        end
        cap = cap_reg;
        if (peak > cap)
            for (int j = 0; j < 3; j++) sp[j] = scaled_div(sp[j], cap, peak);

        r.left = clip32(sp[0]);
        r.right = clip32(sp[1]);
        r.rear = clip32(sp[2]);
        r.angle = ang[17:0];
        return r;
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("mismatch %s: got %0d expected %0d", what, $signed(got), $signed(want));
        fail_count++;
    endtask

    initial fail_count = 0;
    assign pending_count = wheel_queue.size();

    always @(posedge aclk) begin
        wheel_cmd_t want, got;
        if (!aresetn) begin
            lim_reg <= 17'd32768;
            base_reg <= 20'd65536;
            track_reg <= 20'd65536;
            cap_reg <= 31'd2621440;
            wheel_queue.delete();
        end else begin
            // Register writes take effect for later items.
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    twk_pkg::REG_STEER_LIMIT: lim_reg <= cfg_data[16:0];
                    twk_pkg::REG_WHEELBASE:   base_reg <= cfg_data[19:0];
                    twk_pkg::REG_TRACK:       track_reg <= cfg_data[19:0];
                    twk_pkg::REG_SPEED_CAP:   cap_reg <= cfg_data;
                    default: ;
                endcase
            end
            if (s_tvalid && s_tready)
                wheel_queue.insert(wheel_queue.size(),
                                   tricycle_kinematics(s_tdata[31:0], s_tdata[63:32]));
            if (m_tvalid && m_tready) begin
                got.left = m_tdata[31:0];
                got.right = m_tdata[63:32];
                got.rear = m_tdata[95:64];
                got.angle = m_tdata[113:96];
                if (wheel_queue.size() == 0) begin
                    report_mismatch("unexpected result item", 32'd0, 32'd0);
                end else begin
                    want = wheel_queue.pop_front();
                    if (got.left !== want.left)
                        report_mismatch("left_speed", got.left, want.left);
                    if (got.right !== want.right)
                        report_mismatch("right_speed", got.right, want.right);
                    if (got.rear !== want.rear)
                        report_mismatch("rear_speed", got.rear, want.rear);
                    if (got.angle !== want.angle)
                        report_mismatch("steer_angle", 32'(signed'(got.angle)),
                                        32'(signed'(want.angle)));
                end
            end
        end
    end
endmodule

`default_nettype wire

[sim/tb.sv]
`default_nettype none

module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int DRAIN_CYCLES = 400;

    logic         aclk;
    logic         aresetn;
    logic         s_tvalid;
    logic         s_tready;
    logic [63:0]  s_tdata;     // fwd_speed, turn_rate
    logic         m_tvalid;
    logic         m_tready;
    logic [119:0] m_tdata;     // left, right, rear, steer_angle
    logic         cfg_valid;
    logic         cfg_ready;
    logic [1:0]   cfg_index;
    logic [30:0]  cfg_data;
    int           fail_count;
    int           pending_count;
    bit           calm;
    bit           hold_off;

    tricycle_wheel_kinematics_top dut (.*);

    tb_kinematics_checker checker_i (.*);

    initial begin
        aclk = 0;
        forever #1 aclk = ~aclk;
    end

    // Random field value biased toward the extremes and small magnitudes.
    function automatic logic [31:0] pick_speed();
        case ($urandom_range(0, 9))
            0: return 32'h8000_0000;
            1: return 32'h7fff_ffff;
            2: return 0;
            3, 4: return $urandom;
            default: return $urandom_range(0, 32'h0020_0000) - 32'h0010_0000;
        endcase
    endfunction

    // Offer one command and wait until it is taken; valid stays high after
    // the accepting edge so that the next item can follow back to back.
    task automatic send_cmd(input logic [31:0] v, input logic [31:0] w);
        int gap;
        if (!calm && $urandom_range(0, 5) == 0) begin
            gap = $urandom_range(1, 17);
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {w, v};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
    endtask

    // Write one register; valid is dropped by the caller after the last write.
    task automatic write_reg(input logic [1:0] idx, input logic [30:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
    endtask

    // Stop offering, wait for every result, then let the pipeline settle.
    task automatic drain();
        s_tvalid <= 1'b0;
        while (pending_count != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    // Receiver idles in random bursts, plus one long hold-off.
    initial begin
        int gap;
        bit held;
        held = 1'b0;
        m_tready = 1'b0;
        @(posedge aresetn);
        forever begin
            if (hold_off && !held) begin
                m_tready <= 1'b0;
                repeat (600) @(posedge aclk);
                held = 1'b1;
            end else if (!calm && $urandom_range(0, 4) == 0) begin
                gap = $urandom_range(1, 17);
                m_tready <= 1'b0;
                repeat (gap) @(posedge aclk);
            end else begin
                m_tready <= 1'b1;
                @(posedge aclk);
            end
        end
    end

    initial begin
        #5_000_000;
        $display("tb NOT OK");
        $finish;
    end

    initial begin
        s_tvalid = 1'b0;
        s_tdata = '0;
        cfg_valid = 1'b0;
        cfg_index = twk_pkg::REG_STEER_LIMIT;
        cfg_data = '0;
        calm = 1'b0;
        hold_off = 1'b0;
        aresetn = 1'b0;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed commands at reset settings: extremes and special cases.
        send_cmd(32'h0001_0000, 32'h0000_0000);
        send_cmd(32'h0000_0000, 32'h0001_0000);
        send_cmd(32'h0000_0000, 32'hffff_0000);
        send_cmd(32'h0000_0000, 32'h0000_0000);
        send_cmd(32'h7fff_ffff, 32'h7fff_ffff);
        send_cmd(32'h8000_0000, 32'h8000_0000);
        send_cmd(32'h8000_0000, 32'h7fff_ffff);
        send_cmd(32'h0002_0000, 32'h0000_8000);
        send_cmd(32'hfffe_0000, 32'h0000_8000);
        send_cmd(32'h0000_0001, 32'hffff_ffff);
        send_cmd(32'hffff_ffff, 32'h0000_0001);
        send_cmd(32'h0050_0000, 32'h0000_4000);
        drain();

        // Settings phases, extremes included; each is followed by random items.
        for (int ph = 0; ph < 8; ph++) begin
            case (ph)
                0: begin
                    write_reg(twk_pkg::REG_STEER_LIMIT, 31'd102944);
                    write_reg(twk_pkg::REG_WHEELBASE, 31'd1);
                    write_reg(twk_pkg::REG_TRACK, 31'd0);
                    write_reg(twk_pkg::REG_SPEED_CAP, 31'h7fff_ffff);
                end
                1: begin
                    write_reg(twk_pkg::REG_STEER_LIMIT, 31'h1ffff);
                    write_reg(twk_pkg::REG_WHEELBASE, 31'hfffff);
                    write_reg(twk_pkg::REG_TRACK, 31'hfffff);
                    write_reg(twk_pkg::REG_SPEED_CAP, 31'd0);
                end
                2: begin
                    write_reg(twk_pkg::REG_STEER_LIMIT, 31'd0);
                    write_reg(twk_pkg::REG_WHEELBASE, 31'd0);
                    write_reg(twk_pkg::REG_TRACK, 31'd65536);
                    write_reg(twk_pkg::REG_SPEED_CAP, 31'd65536);
                end
                default: begin
                    write_reg(twk_pkg::REG_STEER_LIMIT, 31'($urandom_range(0, 17'h1ffff)));
                    write_reg(twk_pkg::REG_WHEELBASE, 31'($urandom_range(0, 20'hfffff)));
                    write_reg(twk_pkg::REG_TRACK, 31'($urandom_range(0, 20'hfffff)));
                    write_reg(twk_pkg::REG_SPEED_CAP,
                              (ph == 7) ? 31'($urandom_range(0, 31'h7fff_ffff))
                                        : 31'($urandom_range(0, 31'h0100_0000)));
                end
            endcase
            cfg_valid <= 1'b0;
            if (ph == 3) hold_off = 1'b1;
            calm = (ph == 7);
            for (int n = 0; n < 100; n++) begin
                send_cmd(pick_speed(), pick_speed());
            end
            drain();
        end

        if (fail_count == 0) begin
            $display("tb OK");
        end else begin
            $display("tb NOT OK");
        end
        $finish;
    end
endmodule

`default_nettype wire

[tricycle_wheel_kinematics_top.f]
+incdir+rtl/core
rtl/core/twk_pkg.sv
rtl/core/twk_front.sv
rtl/core/twk_div.sv
rtl/core/twk_back.sv
rtl/core/tricycle_wheel_kinematics_top.sv
sim/tb_kinematics_checker.sv
sim/tb.sv
